[rtl/core/wem_pkg.sv]
// shared constants and types for the windowed effort mean unit
`default_nettype none

package wem_pkg;

    // fixed field widths of the item ports
    localparam int SAMPLE_BITS  = 16;
    localparam int FIELD_LANES  = 8;
    localparam int CFG_W        = 7;
    localparam int COUNT_OUT_W  = 7;

    // parameter defaults
    localparam int LANES_DEF      = 8;
    localparam int MAX_WINDOW_DEF = 64;

    // window length after reset
    localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd1;

    // per-cycle commands from the sequencer to every lane
    typedef struct packed {
        logic wr_en;
        logic add_en;
        logic sub_en;
        logic div_start;
        logic div_step;
    } t_lane_ctl;

endpackage

`default_nettype wire

[rtl/core/wem_lane.sv]
// one lane: sample ring, running total and serial divider
`default_nettype none

module wem_lane #(
    parameter int MAX_WINDOW = wem_pkg::MAX_WINDOW_DEF,
    localparam int ADDR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1),
    localparam int SB     = wem_pkg::SAMPLE_BITS,
    localparam int TOT_W  = SB + $clog2(MAX_WINDOW)
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire  wem_pkg::t_lane_ctl    i_ctl,
    input  wire        [ADDR_W-1:0]     i_wr_addr,
    input  wire        [ADDR_W-1:0]     i_rd_addr,
    input  wire        [SB-1:0]         i_sample,
    input  wire        [CNT_W-1:0]      i_divisor,
    output logic       [SB-1:0]         o_quotient
);

    logic        [SB-1:0]    r_mem [MAX_WINDOW];
    logic        [SB-1:0]    r_rd_data;
    logic signed [TOT_W-1:0] r_total;
    logic signed [TOT_W-1:0] n_total;
    logic        [TOT_W-1:0] r_quo;
    logic        [TOT_W-1:0] n_quo;
    logic        [CNT_W-1:0] r_rem;
    logic        [CNT_W-1:0] n_rem;
    logic                    r_neg;
    logic        [CNT_W:0]   w_rem_shift;
    logic        [TOT_W-1:0] w_mag;
    logic        [TOT_W-1:0] w_signed_quo;

    // sample ring, registered read of the oldest entry
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_sample;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    // running total: add on push and subtract on drop, each only for a present entry
    always_comb begin
        n_total = r_total;
        if (i_ctl.add_en) begin
            n_total = r_total + TOT_W'(signed'(i_sample));
        end else if (i_ctl.sub_en) begin
            n_total = r_total - TOT_W'(signed'(r_rd_data));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else begin
            r_total <= n_total;
        end
    end

    // restoring divide of the total magnitude, one quotient bit a cycle
    assign w_mag       = r_total[TOT_W-1] ? TOT_W'(-r_total) : TOT_W'(r_total);
    assign w_rem_shift = {r_rem, r_quo[TOT_W-1]};

    always_comb begin
        n_quo = r_quo;
        n_rem = r_rem;
        if (i_ctl.div_start) begin
            n_quo = w_mag;
            n_rem = '0;
        end else if (i_ctl.div_step) begin
            if (w_rem_shift >= {1'b0, i_divisor}) begin
                n_rem = CNT_W'(w_rem_shift - {1'b0, i_divisor});
                n_quo = {r_quo[TOT_W-2:0], 1'b1};
            end else begin
                n_rem = w_rem_shift[CNT_W-1:0];
                n_quo = {r_quo[TOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_ctl.div_start) begin
            r_neg <= r_total[TOT_W-1];
        end
    end

    // truncation toward zero: negate the magnitude quotient
    assign w_signed_quo = r_neg ? (~r_quo + TOT_W'(1)) : r_quo;
    assign o_quotient   = w_signed_quo[SB-1:0];

endmodule

`default_nettype wire

[rtl/core/wem_merge.sv]
// output stage: gathers lane quotients and the count into one result register
`default_nettype none

module wem_merge #(
    parameter int LANES      = wem_pkg::LANES_DEF,
    parameter int MAX_WINDOW = wem_pkg::MAX_WINDOW_DEF,
    localparam int CNT_W = $clog2(MAX_WINDOW + 1),
    localparam int SB    = wem_pkg::SAMPLE_BITS,
    localparam int FL    = wem_pkg::FIELD_LANES,
    localparam int CO_W  = wem_pkg::COUNT_OUT_W,
    localparam int EXT_W = (CNT_W > CO_W) ? CNT_W : CO_W
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_load,
    input  wire  [LANES-1:0][SB-1:0]    i_quotients,
    input  wire  [CNT_W-1:0]            i_count,
    input  wire                         i_out_ready,
    output logic                        o_out_valid,
    output logic                        o_can_load,
    output logic [FL-1:0][SB-1:0]       o_means,
    output logic [CO_W-1:0]             o_count
);

    logic                  r_valid;
    logic [FL-1:0][SB-1:0] r_means;
    logic [CO_W-1:0]       r_count;
    logic [FL-1:0][SB-1:0] w_means;
    logic [EXT_W-1:0]      w_count_ext;

    // empty window and missing lanes give zero means
    always_comb begin
        w_means = '0;
        for (int k = 0; k < LANES; k++) begin
            if (i_count != '0) begin
                w_means[k] = i_quotients[k];
            end
        end
    end

    assign w_count_ext = EXT_W'(i_count);
    assign o_can_load  = !r_valid || i_out_ready;

    // result register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_means <= w_means;
            r_count <= w_count_ext[CO_W-1:0];
        end
    end

    assign o_out_valid = r_valid;
    assign o_means     = r_means;
    assign o_count     = r_count;

endmodule

`default_nettype wire

[rtl/core/windowed_effort_mean_unit.sv]
// top level of the windowed effort mean unit: sequencer, flag ring and lanes
// an input transaction runs through the states: a drop of the oldest entry when the ring is full,
//   push, check, one drop and check per entry above the window length, TOT_W divide steps
//   (TOT_W = 22 at the default) and done; no new transaction is taken until it is back in idle
// a finished result waits in the output register while the next transaction runs
// reset (synchronous, active low) empties the window and sets the window length to 1
`default_nettype none

module windowed_effort_mean_unit #(
    parameter int LANES      = wem_pkg::LANES_DEF,
    parameter int MAX_WINDOW = wem_pkg::MAX_WINDOW_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire                                 i_present,
    input  wire  [wem_pkg::SAMPLE_BITS-1:0]     i_effort_0,
    input  wire  [wem_pkg::SAMPLE_BITS-1:0]     i_effort_1,
    input  wire  [wem_pkg::SAMPLE_BITS-1:0]     i_effort_2,
    input  wire  [wem_pkg::SAMPLE_BITS-1:0]     i_effort_3,
    input  wire  [wem_pkg::SAMPLE_BITS-1:0]     i_effort_4,
    input  wire  [wem_pkg::SAMPLE_BITS-1:0]     i_effort_5,
    input  wire  [wem_pkg::SAMPLE_BITS-1:0]     i_effort_6,
    input  wire  [wem_pkg::SAMPLE_BITS-1:0]     i_effort_7,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output logic [wem_pkg::SAMPLE_BITS-1:0]     o_mean_0,
    output logic [wem_pkg::SAMPLE_BITS-1:0]     o_mean_1,
    output logic [wem_pkg::SAMPLE_BITS-1:0]     o_mean_2,
    output logic [wem_pkg::SAMPLE_BITS-1:0]     o_mean_3,
    output logic [wem_pkg::SAMPLE_BITS-1:0]     o_mean_4,
    output logic [wem_pkg::SAMPLE_BITS-1:0]     o_mean_5,
    output logic [wem_pkg::SAMPLE_BITS-1:0]     o_mean_6,
    output logic [wem_pkg::SAMPLE_BITS-1:0]     o_mean_7,
    output logic [wem_pkg::COUNT_OUT_W-1:0]     o_contributing_count,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [wem_pkg::CFG_W-1:0]           i_cfg_data
);

    localparam int SB     = wem_pkg::SAMPLE_BITS;
    localparam int FL     = wem_pkg::FIELD_LANES;
    localparam int CFG_W  = wem_pkg::CFG_W;
    localparam int ADDR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int LIM_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int TOT_W  = SB + $clog2(MAX_WINDOW);
    localparam int STEP_W = $clog2(TOT_W);

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DROP = 3'd1;
    localparam logic [2:0] ST_PUSH = 3'd2;
    localparam logic [2:0] ST_CHK  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]             r_state;
    logic [2:0]             n_state;
    logic [CNT_W-1:0]       r_occ;
    logic [CNT_W-1:0]       n_occ;
    logic [ADDR_W-1:0]      r_oldest;
    logic [ADDR_W-1:0]      n_oldest;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic                   r_post;
    logic                   n_post;
    logic [STEP_W-1:0]      r_step;
    logic [STEP_W-1:0]      n_step;
    logic [CFG_W-1:0]       r_window;
    logic                   r_present;
    logic [FL-1:0][SB-1:0]  r_effort;
    logic                   r_flag_mem [MAX_WINDOW];
    logic                   r_flag_rd;

    logic                   w_in_fire;
    logic                   w_load;
    logic                   w_can_load;
    logic [LIM_W-1:0]       w_win_ext;
    logic [LIM_W-1:0]       w_limit;
    logic [SUM_W-1:0]       w_slot_sum;
    logic [SUM_W-1:0]       w_slot_wrap;
    logic [ADDR_W-1:0]      w_slot;
    logic [ADDR_W-1:0]      w_oldest_inc;
    wem_pkg::t_lane_ctl     w_ctl;
    logic [LANES-1:0][SB-1:0] w_quot;
    logic [FL-1:0][SB-1:0]  w_means;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_fire   = i_in_valid && o_in_ready;

    // window length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= wem_pkg::WINDOW_RESET;
        end else if (i_cfg_valid) begin
            r_window <= i_cfg_data;
        end
    end

    // input capture
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_present   <= i_present;
            r_effort[0] <= i_effort_0;
            r_effort[1] <= i_effort_1;
            r_effort[2] <= i_effort_2;
            r_effort[3] <= i_effort_3;
            r_effort[4] <= i_effort_4;
            r_effort[5] <= i_effort_5;
            r_effort[6] <= i_effort_6;
            r_effort[7] <= i_effort_7;
        end
    end

    // window limit clamped to the ring depth
    assign w_win_ext = LIM_W'(r_window);
    assign w_limit   = (w_win_ext > LIM_W'(MAX_WINDOW)) ? LIM_W'(MAX_WINDOW) : w_win_ext;

    // slot of the new entry and next oldest slot, modulo the ring depth
    assign w_slot_sum   = SUM_W'(r_oldest) + SUM_W'(r_occ);
    assign w_slot_wrap  = (w_slot_sum >= SUM_W'(MAX_WINDOW)) ?
                          (w_slot_sum - SUM_W'(MAX_WINDOW)) : w_slot_sum;
    assign w_slot       = w_slot_wrap[ADDR_W-1:0];
    assign w_oldest_inc = (r_oldest == ADDR_W'(MAX_WINDOW - 1)) ?
                          '0 : (r_oldest + ADDR_W'(1));

    // present flag ring, registered read of the oldest entry
    always_ff @(posedge i_clk) begin
        if (r_state == ST_PUSH) begin
            r_flag_mem[w_slot] <= r_present;
        end
        r_flag_rd <= r_flag_mem[r_oldest];
    end

    // sequencer: optional drop when full, push, drops down to the limit, divide, result load
    always_comb begin
        n_state   = r_state;
        n_occ     = r_occ;
        n_oldest  = r_oldest;
        n_count   = r_count;
        n_post    = r_post;
        n_step    = r_step;
        w_ctl     = '0;
        w_load    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    n_post  = 1'b0;
                    n_state = (r_occ == CNT_W'(MAX_WINDOW)) ? ST_DROP : ST_PUSH;
                end
            end
            ST_DROP: begin
                w_ctl.sub_en = r_flag_rd;
                n_count      = r_count - CNT_W'(r_flag_rd);
                n_occ        = r_occ - CNT_W'(1);
                n_oldest     = w_oldest_inc;
                n_state      = r_post ? ST_CHK : ST_PUSH;
            end
            ST_PUSH: begin
                w_ctl.wr_en  = 1'b1;
                w_ctl.add_en = r_present;
                n_count      = r_count + CNT_W'(r_present);
                n_occ        = r_occ + CNT_W'(1);
                n_state      = ST_CHK;
            end
            ST_CHK: begin
                if (LIM_W'(r_occ) > w_limit) begin
                    n_post  = 1'b1;
                    n_state = ST_DROP;
                end else begin
                    w_ctl.div_start = 1'b1;
                    n_step          = '0;
                    n_state         = ST_DIV;
                end
            end
            ST_DIV: begin
                w_ctl.div_step = 1'b1;
                n_step         = r_step + STEP_W'(1);
                if (r_step == STEP_W'(TOT_W - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_can_load) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_occ    <= '0;
            r_oldest <= '0;
            r_count  <= '0;
            r_post   <= 1'b0;
            r_step   <= '0;
        end else begin
            r_state  <= n_state;
            r_occ    <= n_occ;
            r_oldest <= n_oldest;
            r_count  <= n_count;
            r_post   <= n_post;
            r_step   <= n_step;
        end
    end

    // lanes
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        wem_lane #(
            .MAX_WINDOW (MAX_WINDOW)
        ) u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_wr_addr  (w_slot),
            .i_rd_addr  (r_oldest),
            .i_sample   (r_effort[g]),
            .i_divisor  (r_count),
            .o_quotient (w_quot[g])
        );
    end

    // result merge
    wem_merge #(
        .LANES      (LANES),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .i_quotients (w_quot),
        .i_count     (r_count),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_can_load  (w_can_load),
        .o_means     (w_means),
        .o_count     (o_contributing_count)
    );

    assign o_mean_0 = w_means[0];
    assign o_mean_1 = w_means[1];
    assign o_mean_2 = w_means[2];
    assign o_mean_3 = w_means[3];
    assign o_mean_4 = w_means[4];
    assign o_mean_5 = w_means[5];
    assign o_mean_6 = w_means[6];
    assign o_mean_7 = w_means[7];

endmodule

`default_nettype wire

[tb/sv/windowed_effort_mean_unit_checker.sv]
`timescale 1ns / 1ps
// checker for the windowed effort mean unit: tracks the window and compares every result
module windowed_effort_mean_unit_checker (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    input  wire                                 i_in_ready,
    input  wire                                 i_present,
    input  wire  [wem_pkg::SAMPLE_BITS-1:0]     i_effort_0,
    input  wire  [wem_pkg::SAMPLE_BITS-1:0]     i_effort_1,
    input  wire  [wem_pkg::SAMPLE_BITS-1:0]     i_effort_2,
    input  wire  [wem_pkg::SAMPLE_BITS-1:0]     i_effort_3,
    input  wire  [wem_pkg::SAMPLE_BITS-1:0]     i_effort_4,
    input  wire  [wem_pkg::SAMPLE_BITS-1:0]     i_effort_5,
    input  wire  [wem_pkg::SAMPLE_BITS-1:0]     i_effort_6,
    input  wire  [wem_pkg::SAMPLE_BITS-1:0]     i_effort_7,
    input  wire                                 i_out_valid,
    input  wire                                 i_out_ready,
    input  wire  [wem_pkg::SAMPLE_BITS-1:0]     i_mean_0,
    input  wire  [wem_pkg::SAMPLE_BITS-1:0]     i_mean_1,
    input  wire  [wem_pkg::SAMPLE_BITS-1:0]     i_mean_2,
    input  wire  [wem_pkg::SAMPLE_BITS-1:0]     i_mean_3,
    input  wire  [wem_pkg::SAMPLE_BITS-1:0]     i_mean_4,
    input  wire  [wem_pkg::SAMPLE_BITS-1:0]     i_mean_5,
    input  wire  [wem_pkg::SAMPLE_BITS-1:0]     i_mean_6,
    input  wire  [wem_pkg::SAMPLE_BITS-1:0]     i_mean_7,
    input  wire  [wem_pkg::COUNT_OUT_W-1:0]     i_contributing_count,
    input  wire                                 i_cfg_valid,
    input  wire                                 i_cfg_ready,
    input  wire  [wem_pkg::CFG_W-1:0]           i_cfg_data,
    output int                                  o_mismatches,
    output int                                  o_outstanding
);
    import wem_pkg::*;

    localparam int RING_DEPTH = MAX_WINDOW_DEF;

    typedef logic [FIELD_LANES-1:0][SAMPLE_BITS-1:0] t_lane_vec;

    typedef struct packed {
        t_lane_vec               mean;
        logic [COUNT_OUT_W-1:0]  count;
    } t_window_mean;

    // model of the window contents
    logic signed [SAMPLE_BITS-1:0] ring_samples [RING_DEPTH][FIELD_LANES];
    bit                            ring_present [RING_DEPTH];
    longint                        lane_sum [FIELD_LANES];
    int                            present_cnt;
    int                            fill;
    int                            head;
    logic [CFG_W-1:0]              win_len;

    t_window_mean                  mean_q [$];

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
    end

    // remove the oldest entry from the window
    function automatic void retire_oldest();
        if (fill == 0) return;
        if (ring_present[head]) begin
            for (int k = 0; k < FIELD_LANES; k++)
                lane_sum[k] -= longint'(ring_samples[head][k]);
            present_cnt--;
        end
        head = (head + 1) % RING_DEPTH;
        fill--;
    endfunction

    // push one measurement, trim to the window length, return the means
    function automatic t_window_mean advance_window(input bit pres, input t_lane_vec samples);
        t_window_mean res;
        int           limit;
        int           slot;
        longint       q;
        limit = (int'(win_len) > RING_DEPTH) ? RING_DEPTH : int'(win_len);
        if (fill >= RING_DEPTH) retire_oldest();
        slot = (head + fill) % RING_DEPTH;
        ring_present[slot] = pres;
        for (int k = 0; k < FIELD_LANES; k++) begin
            ring_samples[slot][k] = pres ? samples[k] : '0;
            lane_sum[k] += longint'(ring_samples[slot][k]);
        end
        if (pres) present_cnt++;
        fill++;
        while (fill > limit) retire_oldest();
        for (int k = 0; k < FIELD_LANES; k++) begin
            q = (present_cnt != 0) ? lane_sum[k] / longint'(present_cnt) : 0;
            res.mean[k] = q[SAMPLE_BITS-1:0];
        end
        res.count = present_cnt[COUNT_OUT_W-1:0];
        return res;
    endfunction

    // watch the three channels
    always @(posedge i_clk) begin
        t_window_mean got;
        t_window_mean want;
        if (!i_rst_n) begin
            for (int k = 0; k < FIELD_LANES; k++) lane_sum[k] = 0;
            present_cnt = 0;
            fill        = 0;
            head        = 0;
            win_len     = WINDOW_RESET;
            mean_q.delete();
        end else begin
            // result transaction first, so a result never matches the item of the same edge
            if (i_out_valid && i_out_ready) begin
                got.mean  = {i_mean_7, i_mean_6, i_mean_5, i_mean_4,
                             i_mean_3, i_mean_2, i_mean_1, i_mean_0};
                got.count = i_contributing_count;
                if (mean_q.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, got count %0d",
                             $time, got.count);
                    o_mismatches++;
                end else begin
                    want = mean_q.pop_front();
                    for (int k = 0; k < FIELD_LANES; k++) begin
                        if (got.mean[k] !== want.mean[k]) begin
                            $display("%0t ns: mean_%0d mismatch, expected %0d, got %0d",
                                     $time, k, $signed(want.mean[k]), $signed(got.mean[k]));
                            o_mismatches++;
                        end
                    end
                    if (got.count !== want.count) begin
                        $display("%0t ns: contributing_count mismatch, expected %0d, got %0d",
                                 $time, want.count, got.count);
                        o_mismatches++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                win_len = i_cfg_data;
            if (i_in_valid && i_in_ready)
                mean_q.insert(mean_q.size(), advance_window(i_present,
                    {i_effort_7, i_effort_6, i_effort_5, i_effort_4,
                     i_effort_3, i_effort_2, i_effort_1, i_effort_0}));
        end
        o_outstanding = mean_q.size();
    end

endmodule

[tb/sv/windowed_effort_mean_unit_tb.sv]
`timescale 1ns / 1ps
// testbench top for the windowed effort mean unit: stimulus, stalls, watchdog and verdict
module windowed_effort_mean_unit_tb;
    import wem_pkg::*;

    localparam int                RANDOM_ITEMS = 650;
    localparam int                IDLE_LIMIT   = 3000;
    localparam int                DRAIN_CYCLES = 4 + 22 + 2 * MAX_WINDOW_DEF + 50;
    localparam logic [CFG_W-1:0]  WIN_OFF      = '0;
    localparam logic [CFG_W-1:0]  WIN_MIN      = 7'd1;
    localparam logic [CFG_W-1:0]  WIN_FULL     = CFG_W'(MAX_WINDOW_DEF);
    localparam logic [CFG_W-1:0]  WIN_TOP      = '1;
    localparam logic [15:0]       EFF_MAX      = 16'h7FFF;
    localparam logic [15:0]       EFF_MIN      = 16'h8000;
    localparam logic [15:0]       EFF_NEG1     = 16'hFFFF;

    typedef logic [FIELD_LANES-1:0][SAMPLE_BITS-1:0] t_lane_vec;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_ready;
    logic                    present   = 1'b0;
    t_lane_vec               effort    = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    t_lane_vec               mean;
    logic [COUNT_OUT_W-1:0]  count;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_W-1:0]        cfg_data  = '0;

    int  mismatches;
    int  outstanding;
    bit  calm        = 1'b0;
    int  stall_left  = 0;
    int  idle_cycles = 0;
    int  items_seen  = 0;
    int  absent_seen = 0;
    int  results_seen = 0;
    int  cfg_writes  = 0;

    // clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    windowed_effort_mean_unit u_dut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_in_valid           (in_valid),
        .o_in_ready           (in_ready),
        .i_present            (present),
        .i_effort_0           (effort[0]),
        .i_effort_1           (effort[1]),
        .i_effort_2           (effort[2]),
        .i_effort_3           (effort[3]),
        .i_effort_4           (effort[4]),
        .i_effort_5           (effort[5]),
        .i_effort_6           (effort[6]),
        .i_effort_7           (effort[7]),
        .o_out_valid          (out_valid),
        .i_out_ready          (out_ready),
        .o_mean_0             (mean[0]),
        .o_mean_1             (mean[1]),
        .o_mean_2             (mean[2]),
        .o_mean_3             (mean[3]),
        .o_mean_4             (mean[4]),
        .o_mean_5             (mean[5]),
        .o_mean_6             (mean[6]),
        .o_mean_7             (mean[7]),
        .o_contributing_count (count),
        .i_cfg_valid          (cfg_valid),
        .o_cfg_ready          (cfg_ready),
        .i_cfg_data           (cfg_data)
    );

    windowed_effort_mean_unit_checker u_checker (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_in_valid           (in_valid),
        .i_in_ready           (in_ready),
        .i_present            (present),
        .i_effort_0           (effort[0]),
        .i_effort_1           (effort[1]),
        .i_effort_2           (effort[2]),
        .i_effort_3           (effort[3]),
        .i_effort_4           (effort[4]),
        .i_effort_5           (effort[5]),
        .i_effort_6           (effort[6]),
        .i_effort_7           (effort[7]),
        .i_out_valid          (out_valid),
        .i_out_ready          (out_ready),
        .i_mean_0             (mean[0]),
        .i_mean_1             (mean[1]),
        .i_mean_2             (mean[2]),
        .i_mean_3             (mean[3]),
        .i_mean_4             (mean[4]),
        .i_mean_5             (mean[5]),
        .i_mean_6             (mean[6]),
        .i_mean_7             (mean[7]),
        .i_contributing_count (count),
        .i_cfg_valid          (cfg_valid),
        .i_cfg_ready          (cfg_ready),
        .i_cfg_data           (cfg_data),
        .o_mismatches         (mismatches),
        .o_outstanding        (outstanding)
    );

    // result side back-pressure: mostly short stalls, a few long ones
    always @(negedge clk) begin
        int r;
        if (stall_left > 0) begin
            stall_left--;
        end else if (calm) begin
            out_ready = 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                out_ready = 1'b1;
            end else if (r < 95) begin
                out_ready  = 1'b0;
                stall_left = $urandom_range(0, 3);
            end else begin
                out_ready  = 1'b0;
                stall_left = $urandom_range(20, 80);
            end
        end
    end

    // watchdog and transaction counters
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (in_valid && in_ready) begin
                items_seen++;
                if (!present) absent_seen++;
            end
            if (out_valid && out_ready) results_seen++;
            if (cfg_valid && cfg_ready) cfg_writes++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t ns: no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("windowed_effort_mean_unit test failed");
                $finish;
            end
        end
    end

    // sender gap: mostly none or short, sometimes long
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    // effort sample biased toward the range limits
    function automatic logic [15:0] pick_effort();
        case ($urandom_range(0, 9))
            0: return EFF_MIN;
            1: return EFF_MAX;
            2: return '0;
            3: return EFF_NEG1;
            4: return 16'($urandom_range(0, 511)) - 16'd256;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_lane_vec fill_lanes(input logic [15:0] v);
        t_lane_vec e;
        for (int k = 0; k < FIELD_LANES; k++) e[k] = v;
        return e;
    endfunction

    // one measurement transaction, held until accepted
    task automatic push_measurement(input bit pres, input t_lane_vec e, input int gap);
        @(negedge clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        present  = pres;
        effort   = e;
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
    endtask

    // window length write, only once the unit has drained
    task automatic set_window(input logic [CFG_W-1:0] len);
        @(negedge clk);
        in_valid = 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (2) @(negedge clk);
        cfg_data  = len;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    initial begin
        t_lane_vec        e;
        logic [CFG_W-1:0] len;
        int               n;
        int               pres_pct;
        int               sent;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset window of one: limits, absent measurement with junk payload
        push_measurement(1'b1, fill_lanes(EFF_MAX), 0);
        push_measurement(1'b1, fill_lanes(EFF_MIN), 0);
        push_measurement(1'b0, fill_lanes(EFF_NEG1), 1);
        for (int k = 0; k < FIELD_LANES; k++) e[k] = k[0] ? EFF_MAX : EFF_MIN;
        push_measurement(1'b1, e, 0);

        // full window: accumulate extremes and odd totals for truncation
        set_window(WIN_FULL);
        push_measurement(1'b1, fill_lanes(EFF_MIN), 0);
        push_measurement(1'b1, fill_lanes(EFF_MIN), 0);
        push_measurement(1'b0, fill_lanes(EFF_MAX), 2);
        push_measurement(1'b1, fill_lanes(EFF_MAX), 0);
        for (int k = 0; k < FIELD_LANES; k++) e[k] = 16'(-(k + 1));
        push_measurement(1'b1, e, 0);
        push_measurement(1'b1, fill_lanes(16'h0001), 0);

        // lowering the window drops several entries at once
        set_window(7'd3);
        push_measurement(1'b1, fill_lanes(16'h0155), 0);
        push_measurement(1'b0, fill_lanes('0), 0);

        // zero length window: everything is dropped
        set_window(WIN_OFF);
        push_measurement(1'b1, fill_lanes(EFF_MAX), 0);
        push_measurement(1'b0, fill_lanes(EFF_MIN), 0);

        // length above the ring size acts as the ring size
        set_window(WIN_TOP);
        push_measurement(1'b1, fill_lanes(EFF_NEG1), 0);
        push_measurement(1'b1, fill_lanes(EFF_MIN), 0);

        set_window(7'd2);
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < FIELD_LANES; k++) e[k] = pick_effort();
            push_measurement(1'b1, e, pick_gap());
        end

        // random phases: window setting, presence density and idling per phase
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 19))
                0, 1:          len = WIN_OFF;
                2, 3, 4:       len = WIN_MIN;
                5, 6, 7:       len = CFG_W'($urandom_range(2, 4));
                8, 9, 10, 11, 12: len = CFG_W'($urandom_range(5, MAX_WINDOW_DEF - 1));
                13, 14, 15:    len = WIN_FULL;
                default:       len = CFG_W'($urandom_range(MAX_WINDOW_DEF + 1, 127));
            endcase
            // first phase always wraps the ring
            if (sent == 0) len = WIN_TOP;
            set_window(len);
            calm = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 4))
                0:       pres_pct = 100;
                1:       pres_pct = 30;
                2:       pres_pct = 5;
                default: pres_pct = 80;
            endcase
            n = (int'(len) >= MAX_WINDOW_DEF) ? $urandom_range(40, 100) : $urandom_range(4, 40);
            if (sent == 0) n = 90;
            for (int i = 0; i < n; i++) begin
                for (int k = 0; k < FIELD_LANES; k++) e[k] = pick_effort();
                push_measurement($urandom_range(0, 99) < pres_pct, e, pick_gap());
                sent++;
            end
        end
        calm = 1'b0;

        // drain and wait out any late result
        @(negedge clk);
        in_valid = 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d measurements (%0d absent) over %0d window settings,",
                 items_seen, absent_seen, cfg_writes);
        $display("lengths zero through 127 with ring wrap, %0d results compared", results_seen);
        if (mismatches == 0) begin
            $display("windowed_effort_mean_unit test passed");
        end else begin
            $display("windowed_effort_mean_unit test failed");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/wem_pkg.sv
rtl/core/wem_lane.sv
rtl/core/wem_merge.sv
rtl/core/windowed_effort_mean_unit.sv
tb/sv/windowed_effort_mean_unit_checker.sv
tb/sv/windowed_effort_mean_unit_tb.sv
